>>> src/dec_pkg.sv
package dec_pkg;

   localparam int TABLE_POINTS = 256;
   localparam int ADDR_WIDTH   = $clog2(TABLE_POINTS);
   localparam int PHASE_WIDTH  = 32;
   localparam int COUNT_WIDTH  = 24;
   localparam int WORD_WIDTH   = 32;
   localparam int EXT_WIDTH    = 48;
   localparam int FRAC_BITS    = 16;
   localparam int SPLIT_BITS   = 24;
   localparam int DUTY_WIDTH   = 8;
   localparam int SAMPLES_WIDTH = 24;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_INCREMENT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GROWTH_FRACTION = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SWEEP_SAMPLES   = 2'd2;

   localparam logic [WORD_WIDTH-1:0]    START_INCREMENT_RESET = 32'd4294967;
   localparam logic [WORD_WIDTH-1:0]    GROWTH_FRACTION_RESET = 32'd25317474;
   localparam logic [SAMPLES_WIDTH-1:0] SWEEP_SAMPLES_RESET   = 24'd200000;

   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef logic [TABLE_POINTS-1:0][DUTY_WIDTH-1:0] rom_type;

   // Control for one processing step, from the top level to the state holders.
   typedef struct packed {
      logic fire;
      logic restart;
   } step_type;

   // Shift-and-subtract quotient, used only while the table is built.
   function automatic longint unsigned quotient_u64(longint unsigned num,
                                                     longint unsigned den);
      longint unsigned quo;
      longint unsigned rest;
      int              b;
      quo  = 64'd0;
      rest = 64'd0;
      for (b = 63; b >= 0; b--) begin
         rest = {rest[62:0], num[b]};
         quo  = quo << 1;
         if (rest >= den) begin
            rest = rest - den;
            quo  = quo | 64'd1;
         end
      end
      return quo;
   endfunction

   // Q30 Taylor series over [0, pi/2]: odd terms give sine, even terms cosine.
   function automatic longint unsigned series_q30(longint unsigned x, bit odd);
      longint unsigned term;
      longint unsigned k;
      longint          sum;
      int              n;
      term = odd ? x : Q30_ONE;
      sum  = longint'(term);
      k    = odd ? 64'd1 : 64'd0;
      for (n = 1; n <= 12; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = quotient_u64(term, (k + 64'd1) * (k + 64'd2));
         k    = k + 64'd2;
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > longint'(Q30_ONE)) begin
         sum = longint'(Q30_ONE);
      end
      return unsigned'(sum);
   endfunction

   // Offset sine table, worked out at elaboration.
   function automatic rom_type build_rom();
      rom_type         rom;
      longint unsigned q;
      longint unsigned quad;
      longint unsigned rem;
      longint unsigned x;
      longint unsigned mag;
      longint unsigned num;
      longint unsigned d;
      int              i;
      for (i = 0; i < TABLE_POINTS; i++) begin
         q    = 64'(4 * i);
         quad = q / TABLE_POINTS;
         rem  = q % TABLE_POINTS;
         x    = (HALF_PI_Q30 * rem) / TABLE_POINTS;
         mag  = series_q30(x, quad[0] == 1'b0);
         if (quad >= 64'd2) begin
            num = 64'd255 * (Q30_ONE - mag);
         end else begin
            num = 64'd255 * (Q30_ONE + mag);
         end
         d = num >> 31;
         if (d > 64'd255) begin
            d = 64'd255;
         end
         rom[i] = d[DUTY_WIDTH-1:0];
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

endpackage

>>> src/dec_ifs.sv
interface dec_req_if import dec_pkg::*;;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface dec_rsp_if import dec_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [DUTY_WIDTH-1:0] duty;
   logic                  sweep_wrapped;
   logic [WORD_WIDTH-1:0] current_increment;

   modport source (output valid, output duty, output sweep_wrapped,
                   output current_increment, input ready);
   modport sink (input valid, input duty, input sweep_wrapped,
                 input current_increment, output ready);
endinterface

>>> src/dec_sweep.sv
module dec_sweep import dec_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  step_type                 step,
   input  logic [WORD_WIDTH-1:0]    start_increment,
   input  logic [WORD_WIDTH-1:0]    growth_fraction,
   input  logic [SAMPLES_WIDTH-1:0] sweep_samples,
   output logic [WORD_WIDTH-1:0]    word,
   output logic                     wrapped
);

   localparam int PROD_WIDTH = SPLIT_BITS + WORD_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + 1;
   localparam int CMP_WIDTH  = COUNT_WIDTH + SAMPLES_WIDTH + 1;

   logic [EXT_WIDTH-1:0]   ext_ff, ext_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic [EXT_WIDTH-1:0]   ext_start;
   logic [EXT_WIDTH-1:0]   ext_cur;
   logic [COUNT_WIDTH-1:0] count_cur;
   logic [PROD_WIDTH-1:0]  prod_hi;
   logic [PROD_WIDTH-1:0]  prod_lo;
   logic [ACC_WIDTH-1:0]   acc;
   logic [EXT_WIDTH:0]     grown_sum;
   logic [EXT_WIDTH-1:0]   ext_grown;
   logic [COUNT_WIDTH:0]   count_next;
   logic [COUNT_WIDTH-1:0] count_sat;

   assign ext_start = {EXT_WIDTH'(start_increment)} << FRAC_BITS;

   // A restart takes effect before this word's tick.
   assign ext_cur   = step.restart ? ext_start : ext_ff;
   assign count_cur = step.restart ? '0 : count_ff;
   assign word      = ext_cur[FRAC_BITS +: WORD_WIDTH];

   // The 48 by 32 growth product is split into two 24 by 32 halves.
   assign prod_hi = PROD_WIDTH'(ext_cur[EXT_WIDTH-1:SPLIT_BITS]) * PROD_WIDTH'(growth_fraction);
   assign prod_lo = PROD_WIDTH'(ext_cur[SPLIT_BITS-1:0]) * PROD_WIDTH'(growth_fraction);
   assign acc     = ACC_WIDTH'(prod_hi) + ACC_WIDTH'(prod_lo[PROD_WIDTH-1:SPLIT_BITS]);

   assign grown_sum = (EXT_WIDTH+1)'(ext_cur) + (EXT_WIDTH+1)'(acc[ACC_WIDTH-1:FRAC_BITS]);
   assign ext_grown = grown_sum[EXT_WIDTH] ? {EXT_WIDTH{1'b1}} : grown_sum[EXT_WIDTH-1:0];

   assign count_next = (COUNT_WIDTH+1)'(count_cur) + (COUNT_WIDTH+1)'(1);
   assign count_sat  = count_next[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}}
                                               : count_next[COUNT_WIDTH-1:0];
   assign wrapped    = CMP_WIDTH'(count_next) >= CMP_WIDTH'(sweep_samples);

   always_comb begin
      ext_in   = ext_ff;
      count_in = count_ff;
      if (step.fire) begin
         if (wrapped) begin
            ext_in   = ext_start;
            count_in = '0;
         end else begin
            ext_in   = ext_grown;
            count_in = count_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff   <= {EXT_WIDTH'(START_INCREMENT_RESET)} << FRAC_BITS;
         count_ff <= '0;
      end else begin
         ext_ff   <= ext_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> src/dec_phase.sv
module dec_phase import dec_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [WORD_WIDTH-1:0] word,
   output logic [DUTY_WIDTH-1:0] duty
);

   logic [PHASE_WIDTH-1:0] phase_ff, phase_in;
   logic [PHASE_WIDTH-1:0] phase_sum;
   logic [ADDR_WIDTH-1:0]  rom_addr;

   assign phase_sum = phase_ff + PHASE_WIDTH'(word);
   assign phase_in  = fire ? phase_sum : phase_ff;

   // The table is read at the advanced phase, by its top bits.
   assign rom_addr = phase_sum[PHASE_WIDTH-1 -: ADDR_WIDTH];
   assign duty     = SINE_ROM[rom_addr];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

>>> src/dds_exponential_chirp_unit.sv
// Channel    Direction  Contents
// req_if     in         restart (1 bit): one sample tick per word
// rsp_if     out        duty (8), sweep_wrapped (1), current_increment (32)
// csr_*      in         write enable, index (0 start, 1 growth, 2 length), data (32)
//
// An accepted word is held in the input register and, once the result register is free, worked
// into the result register; one word per cycle is sustained while results are taken.
// The growth multiply and the tuning-word update form the loop through the sweep register.
// Reset is synchronous and restores register defaults, a zero phase and the start word.
// A stalled result holds; the input register keeps taking words until it is full too.
module dds_exponential_chirp_unit import dec_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   dec_req_if.sink                    req_if,
   dec_rsp_if.source                  rsp_if,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic [WORD_WIDTH-1:0]    start_increment_ff, start_increment_in;
   logic [WORD_WIDTH-1:0]    growth_fraction_ff, growth_fraction_in;
   logic [SAMPLES_WIDTH-1:0] sweep_samples_ff, sweep_samples_in;

   logic in_valid_ff, in_valid_in;
   logic in_restart_ff, in_restart_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DUTY_WIDTH-1:0] duty_ff, duty_in;
   logic                  wrapped_ff, wrapped_in;
   logic [WORD_WIDTH-1:0] increment_ff, increment_in;

   logic                  advance;
   logic                  req_take;
   step_type              step;
   logic [WORD_WIDTH-1:0] word;
   logic                  wrapped;
   logic [DUTY_WIDTH-1:0] duty;

   always_comb begin
      start_increment_in = start_increment_ff;
      growth_fraction_in = growth_fraction_ff;
      sweep_samples_in   = sweep_samples_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_START_INCREMENT: start_increment_in = csr_write_data[WORD_WIDTH-1:0];
            CSR_GROWTH_FRACTION: growth_fraction_in = csr_write_data[WORD_WIDTH-1:0];
            CSR_SWEEP_SAMPLES:   sweep_samples_in   = csr_write_data[SAMPLES_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // The result register frees up when empty or when its word is taken.
   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !in_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;
   assign step.fire    = in_valid_ff && advance;
   assign step.restart = in_restart_ff;

   assign in_valid_in   = req_take ? 1'b1 : (step.fire ? 1'b0 : in_valid_ff);
   assign in_restart_in = req_take ? req_if.restart : in_restart_ff;

   dec_sweep u_sweep (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .start_increment (start_increment_ff),
      .growth_fraction (growth_fraction_ff),
      .sweep_samples   (sweep_samples_ff),
      .word            (word),
      .wrapped         (wrapped)
   );

   dec_phase u_phase (
      .clock (clock),
      .reset (reset),
      .fire  (step.fire),
      .word  (word),
      .duty  (duty)
   );

   assign rsp_valid_in = step.fire ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
   assign duty_in      = step.fire ? duty : duty_ff;
   assign wrapped_in   = step.fire ? wrapped : wrapped_ff;
   assign increment_in = step.fire ? word : increment_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_increment_ff <= START_INCREMENT_RESET;
         growth_fraction_ff <= GROWTH_FRACTION_RESET;
         sweep_samples_ff   <= SWEEP_SAMPLES_RESET;
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         start_increment_ff <= start_increment_in;
         growth_fraction_ff <= growth_fraction_in;
         sweep_samples_ff   <= sweep_samples_in;
         in_valid_ff        <= in_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_restart_ff <= in_restart_in;
      duty_ff       <= duty_in;
      wrapped_ff    <= wrapped_in;
      increment_ff  <= increment_in;
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.duty              = duty_ff;
   assign rsp_if.sweep_wrapped     = wrapped_ff;
   assign rsp_if.current_increment = increment_ff;

   // A worked word always lands in the result register.
   assert property (@(posedge clock) disable iff (reset)
      step.fire |=> rsp_if.valid)
      else $error("worked word did not reach the result register");

   // With the result register empty, the input side never stalls.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_if.valid |-> req_if.ready)
      else $error("input stalled with an empty result register");

   // A restarted tick reports the start word as its tuning word.
   assert property (@(posedge clock) disable iff (reset)
      (step.fire && step.restart) |=>
         rsp_if.current_increment == $past(start_increment_ff))
      else $error("restart did not reload the start word");

endmodule

>>> tb/tb_dds_exponential_chirp_unit.sv
module tb_dds_exponential_chirp_unit;
   import dec_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam longint unsigned UNITY_Q30        = 64'd1073741824;
   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
   localparam longint unsigned TUNING_EXT_MAX   = (64'd1 << 48) - 64'd1;
   localparam logic [24:0]     SWEEP_COUNT_MAX  = 25'h0FF_FFFF;
   localparam int              QUIET_LIMIT      = 1000;

   typedef struct {
      logic [DUTY_WIDTH-1:0] duty;
      logic                  wrapped;
      logic [WORD_WIDTH-1:0] word;
   } tone_type;

   logic clock = 1'b0;
   logic reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   dec_req_if req_bus ();
   dec_rsp_if rsp_bus ();

   dds_exponential_chirp_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the tone generator: registers and sweep state.
   logic [DUTY_WIDTH-1:0]    duty_lut [0:TABLE_POINTS-1];
   logic [WORD_WIDTH-1:0]    model_start;
   logic [WORD_WIDTH-1:0]    model_growth;
   logic [SAMPLES_WIDTH-1:0] model_length;
   logic [PHASE_WIDTH-1:0]   tone_phase;
   logic [EXT_WIDTH-1:0]     tuning_ext;
   logic [COUNT_WIDTH-1:0]   sweep_count;

   tone_type pending_tones [$];
   int    errors        = 0;
   int    ticks_sent    = 0;
   int    restarts_sent = 0;
   int    wraps_seen    = 0;
   int    csr_writes    = 0;
   bit    idle_on       = 1'b1;
   int    rsp_hold_cycles = 0;

   function automatic longint unsigned taylor_q30(longint unsigned angle, bit want_sine);
      longint unsigned term;
      longint unsigned order;
      longint          total;
      int              n;
      term  = want_sine ? angle : UNITY_Q30;
      total = longint'(term);
      order = want_sine ? 64'd1 : 64'd0;
      for (n = 1; n <= 12; n++) begin
         term  = (term * angle) >> 30;
         term  = (term * angle) >> 30;
         term  = term / ((order + 64'd1) * (order + 64'd2));
         order = order + 64'd2;
         if (n % 2 == 1) begin
            total = total - longint'(term);
         end else begin
            total = total + longint'(term);
         end
      end
      if (total < 0) begin
         total = 0;
      end
      if (total > longint'(UNITY_Q30)) begin
         total = longint'(UNITY_Q30);
      end
      return unsigned'(total);
   endfunction

   // Works out one sample tick and advances the mirrored sweep state.
   function automatic tone_type next_tone(bit restart);
      tone_type        t;
      longint unsigned ext64;
      longint unsigned acc;
      longint unsigned delta;
      logic [24:0]     next_count;
      if (restart) begin
         tuning_ext  = {model_start, 16'h0000};
         sweep_count = '0;
      end
      t.word     = tuning_ext[47:16];
      tone_phase = tone_phase + t.word;
      t.duty     = duty_lut[tone_phase[PHASE_WIDTH-1 -: ADDR_WIDTH]];
      ext64 = 64'(tuning_ext);
      acc   = 64'(tuning_ext[47:24]) * 64'(model_growth)
              + ((64'(tuning_ext[23:0]) * 64'(model_growth)) >> 24);
      delta = acc >> 16;
      if (delta > TUNING_EXT_MAX - ext64) begin
         tuning_ext = TUNING_EXT_MAX[EXT_WIDTH-1:0];
      end else begin
         tuning_ext = EXT_WIDTH'(ext64 + delta);
      end
      next_count = 25'(sweep_count) + 25'd1;
      if (next_count >= 25'(model_length)) begin
         tuning_ext  = {model_start, 16'h0000};
         sweep_count = '0;
         t.wrapped   = 1'b1;
      end else begin
         t.wrapped   = 1'b0;
         sweep_count = (next_count > SWEEP_COUNT_MAX) ? SWEEP_COUNT_MAX[23:0] : next_count[23:0];
      end
      return t;
   endfunction

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] index, logic [CSR_DATA_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_START_INCREMENT: model_start  = data;
         CSR_GROWTH_FRACTION: model_growth = data;
         CSR_SWEEP_SAMPLES:   model_length = data[SAMPLES_WIDTH-1:0];
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic set_sweep(logic [31:0] start, logic [31:0] growth, logic [31:0] length);
      write_csr(CSR_START_INCREMENT, start);
      write_csr(CSR_GROWTH_FRACTION, growth);
      write_csr(CSR_SWEEP_SAMPLES, length);
   endtask

   task automatic send_tick(bit restart);
      int gap;
      gap = idle_on ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.restart <= restart;
      do @(posedge clock); while (!req_bus.ready);
      pending_tones.push_back(next_tone(restart));
      ticks_sent++;
      if (restart) begin
         restarts_sent++;
      end
   endtask

   // Stops offering words and waits until every result is in.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_tones.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_tone();
      tone_type want;
      if (rsp_bus.sweep_wrapped === 1'b1) begin
         wraps_seen++;
      end
      if (pending_tones.size() == 0) begin
         $display("%0t: result with nothing expected: duty %0d wrapped %0b word %08h",
                  $time, rsp_bus.duty, rsp_bus.sweep_wrapped, rsp_bus.current_increment);
         errors++;
         return;
      end
      want = pending_tones.pop_front();
      if (rsp_bus.duty !== want.duty) begin
         $display("%0t: duty expected %0d, actual %0d", $time, want.duty, rsp_bus.duty);
         errors++;
      end
      if (rsp_bus.sweep_wrapped !== want.wrapped) begin
         $display("%0t: sweep_wrapped expected %0b, actual %0b",
                  $time, want.wrapped, rsp_bus.sweep_wrapped);
         errors++;
      end
      if (rsp_bus.current_increment !== want.word) begin
         $display("%0t: current_increment expected %08h, actual %08h",
                  $time, want.word, rsp_bus.current_increment);
         errors++;
      end
   endtask

   initial begin : tone_sink
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = idle_on ? $urandom_range(0, 13) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         check_tone();
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_dds_exponential_chirp_unit: errors");
      $finish;
   end

   task automatic test_reset_defaults();
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      drain();
   endtask

   // Largest start word and growth saturate the tuning word on the first tick.
   task automatic test_saturation();
      set_sweep(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      drain();
   endtask

   // With a one-tick sweep, a restart lands on a tick that also ends the sweep.
   task automatic test_restart_on_wrap();
      set_sweep(32'h1234_5678, 32'h0000_0001, 32'd1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      drain();
   endtask

   task automatic test_zero_rates();
      set_sweep(32'h0, 32'h0, 32'h0);
      send_tick(1'b0);
      send_tick(1'b1);
      drain();
   endtask

   // A new start word must not disturb the running sweep until it reloads.
   task automatic test_start_mid_sweep();
      set_sweep(32'd1000, 32'h0100_0000, 32'd5);
      send_tick(1'b1);
      send_tick(1'b0);
      drain();
      write_csr(CSR_START_INCREMENT, 32'd7777);
      repeat (4) send_tick(1'b0);
      drain();
   endtask

   task automatic test_spare_index();
      write_csr(CSR_SPARE_INDEX, 32'hDEAD_BEEF);
      send_tick(1'b0);
      send_tick(1'b0);
      drain();
   endtask

   // The sink holds off while the source keeps offering, so the pipeline fills up.
   task automatic test_backpressure();
      set_sweep(32'h0100_0000, 32'h0004_0000, 32'd7);
      idle_on = 1'b0;
      rsp_hold_cycles = 80;
      repeat (16) send_tick(($urandom_range(0, 9) == 0));
      drain();
      repeat (8) send_tick(1'b0);
      drain();
      idle_on = 1'b1;
   endtask

   task automatic test_random_sweeps();
      int p;
      int count;
      logic [31:0] length;
      for (p = 0; p < 8; p++) begin
         idle_on = (p % 4 != 3);
         case ($urandom_range(0, 9))
            0:       length = 32'd0;
            1:       length = $urandom_range(1, 24'hFF_FFFF);
            2:       length = {8'($urandom_range(0, 255)), 24'h00_0000}
                              | $urandom_range(1, 60);
            default: length = $urandom_range(1, 40);
         endcase
         set_sweep($urandom >> $urandom_range(0, 31), $urandom >> $urandom_range(0, 31),
                   length);
         if ($urandom_range(0, 3) == 0) begin
            write_csr(CSR_SPARE_INDEX, $urandom);
         end
         count = $urandom_range(50, 65);
         send_tick(1'b1);
         repeat (count) send_tick(($urandom_range(0, 11) == 0));
         drain();
      end
      idle_on = 1'b1;
   endtask

   initial begin : run_tests
      longint unsigned q;
      longint unsigned quadrant;
      longint unsigned angle;
      longint unsigned mag;
      longint unsigned level;
      int              i;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.restart  <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;

      // Offset sine table: floor(127.5 + 127.5 sin(2 pi i / N)) in Q30 arithmetic.
      for (i = 0; i < TABLE_POINTS; i++) begin
         q        = 64'(4 * i);
         quadrant = q / TABLE_POINTS;
         angle    = (QUARTER_TURN_Q30 * (q % TABLE_POINTS)) / TABLE_POINTS;
         mag      = taylor_q30(angle, quadrant[0] == 1'b0);
         if (quadrant >= 64'd2) begin
            level = (64'd255 * (UNITY_Q30 - mag)) >> 31;
         end else begin
            level = (64'd255 * (UNITY_Q30 + mag)) >> 31;
         end
         duty_lut[i] = (level > 64'd255) ? 8'hFF : level[7:0];
      end
      model_start  = START_INCREMENT_RESET;
      model_growth = GROWTH_FRACTION_RESET;
      model_length = SWEEP_SAMPLES_RESET;
      tone_phase   = '0;
      tuning_ext   = {START_INCREMENT_RESET, 16'h0000};
      sweep_count  = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_saturation();
      test_restart_on_wrap();
      test_zero_rates();
      test_start_mid_sweep();
      test_spare_index();
      test_backpressure();
      test_random_sweeps();

      drain();
      $display("Run covered %0d sample ticks, %0d with restart, and %0d register writes;",
               ticks_sent, restarts_sent, csr_writes);
      $display("%0d results flagged a sweep wrap, %0d mismatches found.", wraps_seen, errors);
      if (errors == 0) begin
         $display("tb_dds_exponential_chirp_unit: clean");
      end else begin
         $display("tb_dds_exponential_chirp_unit: errors");
      end
      $finish;
   end

endmodule
